// File: rtl/core/depth_feed_packet_decoder_top_defines.svh
// Assertion macros used by the decoder's queue module.
`ifndef DEPTH_FEED_PACKET_DECODER_TOP_DEFINES_SVH
`define DEPTH_FEED_PACKET_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFPD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dfpd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DFPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dfpd assertion failed");

`endif

// File: rtl/core/dfpd_pkg.sv
package dfpd_pkg;

	localparam int LEVEL_COUNT  = 20;
	localparam int HEADER_BYTES = 12;
	localparam int LEVEL_BYTES  = 20;
	localparam int PKT_BYTES    = HEADER_BYTES + LEVEL_BYTES * LEVEL_COUNT;

	localparam int POS_W = 11;
	localparam int OFS_W = 5;
	localparam int LVL_W = 6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [26:0] PRICE_SCALE = 27'd100000000;
	localparam logic [63:0] INT64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic {
		CFG_BID = 1'b0,
		CFG_ASK = 1'b1
	} cfg_idx_t;

	// One queue entry: what one accepted byte produced.
	typedef struct packed {
		logic        has_level;
		logic        has_report;
		logic [31:0] instrument_id;
		logic [31:0] sequence_number;
		logic        side;
		logic [5:0]  level_index;
		logic        last_level;
		logic        present;
		logic [63:0] price_bits;
		logic [63:0] quantity;
		logic [31:0] order_count;
		logic [31:0] bytes_parsed;
	} job_t;

endpackage

// File: rtl/core/dfpd_front.sv
module dfpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        data_byte,
	input  logic              buffer_end,
	input  logic [7:0]        bid_resp,
	input  logic [7:0]        ask_resp,
	output logic              push,
	output dfpd_pkg::job_t    job
);
	import dfpd_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [OFS_W-1:0] ofs_q;
	logic [LVL_W-1:0] lvl_q;
	logic [15:0]      len_q;
	logic [7:0]       code_q;
	logic [31:0]      sec_q;
	logic [31:0]      seq_q;
	logic [63:0]      price_q;
	logic [63:0]      qty_q;
	logic [31:0]      cnt_q;
	logic [31:0]      cons_q;

	logic        in_hdr;
	logic        level_done;
	logic        wrap;
	logic        is_bid;
	logic        is_ask;
	logic        pkt_ok;
	logic [32:0] cons_sum;
	logic [31:0] cons_next;
	logic [31:0] cnt_full;

	assign in_hdr     = pos_q < POS_W'(HEADER_BYTES);
	assign level_done = !in_hdr && ofs_q == OFS_W'(LEVEL_BYTES - 1);
	assign wrap       = pos_q == POS_W'(PKT_BYTES - 1);
	assign is_bid     = code_q == bid_resp;
	assign is_ask     = code_q == ask_resp;
	assign pkt_ok     = len_q == 16'(PKT_BYTES) && (is_bid || is_ask);
	assign cons_sum   = {1'b0, cons_q} + 33'(PKT_BYTES);
	assign cons_next  = !wrap ? cons_q : (cons_sum[32] ? 32'hFFFF_FFFF : cons_sum[31:0]);
	assign cnt_full   = {data_byte, cnt_q[23:0]};

	always_comb begin
		job                 = '0;
		job.has_level       = level_done && pkt_ok;
		job.has_report      = buffer_end;
		job.instrument_id   = sec_q;
		job.sequence_number = seq_q;
		job.side            = !is_bid;
		job.level_index     = lvl_q;
		job.last_level      = lvl_q == LVL_W'(LEVEL_COUNT - 1);
		// Positive price, not NaN, nonzero quantity: sign clear, nonzero, and not an all-ones
		// exponent with a nonzero fraction. Infinity counts as positive.
		job.present         = !price_q[63] && price_q[62:0] != '0 &&
			!(price_q[62:52] == 11'h7FF && price_q[51:0] != '0) && qty_q != '0;
		job.price_bits      = price_q;
		job.quantity        = qty_q;
		job.order_count     = cnt_full;
		job.bytes_parsed    = cons_next;
	end

	assign push = accept && (job.has_level || job.has_report);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ofs_q   <= '0;
			lvl_q   <= '0;
			len_q   <= '0;
			code_q  <= '0;
			sec_q   <= '0;
			seq_q   <= '0;
			price_q <= '0;
			qty_q   <= '0;
			cnt_q   <= '0;
			cons_q  <= '0;
		end else if (accept) begin
			if (in_hdr) begin
				case (pos_q)
					POS_W'(0): len_q[7:0]  <= data_byte;
					POS_W'(1): len_q[15:8] <= data_byte;
					POS_W'(2): code_q      <= data_byte;
					POS_W'(3): ;
					default: begin
						if (pos_q < POS_W'(8)) begin
							sec_q[8*pos_q[1:0] +: 8] <= data_byte;
						end else begin
							seq_q[8*pos_q[1:0] +: 8] <= data_byte;
						end
					end
				endcase
			end else if (ofs_q < OFS_W'(8)) begin
				price_q[8*ofs_q[2:0] +: 8] <= data_byte;
			end else if (ofs_q < OFS_W'(16)) begin
				qty_q[8*ofs_q[2:0] +: 8] <= data_byte;
			end else begin
				cnt_q[8*ofs_q[1:0] +: 8] <= data_byte;
			end

			if (wrap || buffer_end) begin
				pos_q <= '0;
				ofs_q <= '0;
				lvl_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				if (!in_hdr) begin
					if (level_done) begin
						ofs_q <= '0;
						lvl_q <= lvl_q + LVL_W'(1);
					end else begin
						ofs_q <= ofs_q + OFS_W'(1);
					end
				end
			end

			cons_q <= buffer_end ? '0 : cons_next;
		end
	end

endmodule

// File: rtl/core/dfpd_queue.sv
module dfpd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dfpd_pkg::job_t wr_job,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output dfpd_pkg::job_t rd_job
);
	import dfpd_pkg::*;
	`include "depth_feed_packet_decoder_top_defines.svh"

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full   = count_q == QCNT_W'(QUEUE_DEPTH);
	assign empty  = count_q == '0;
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	`DFPD_ASSERT_IMP(a_no_push_full, push, !full)
	`DFPD_ASSERT_IMP(a_no_pop_empty, pop, !empty)
	`DFPD_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + QCNT_W'(1))

endmodule

// File: rtl/core/dfpd_back.sv
module dfpd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  dfpd_pkg::job_t q_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           result_kind,
	output logic [31:0]    instrument_id,
	output logic           side,
	output logic [31:0]    sequence_number,
	output logic [5:0]     level_index,
	output logic [63:0]    price_fixed,
	output logic [63:0]    quantity,
	output logic [31:0]    order_count,
	output logic           level_present,
	output logic           last_level,
	output logic [31:0]    bytes_parsed
);
	import dfpd_pkg::*;

	logic        advance;
	job_t        job_s1, job_s2, job_s3, job_s4, job_q;
	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	logic [53:0] plo_s1;
	logic [52:0] phi_s1;
	logic [79:0] prod_s2;
	logic [53:0] rnd_s3;
	logic signed [12:0] exp_s3;
	logic        zero_s3, sat_s3;
	logic [63:0] fix_s4, fix_q;

	logic [52:0] mant;
	logic [10:0] bexp;
	logic [52:0] top53;
	logic        guard, sticky;
	logic [53:0] rnd_c;
	logic signed [12:0] exp_c;
	logic [12:0] neg_e;
	logic [63:0] wide_r, shl, fix_c;
	logic        show_lvl;

	assign bexp = q_job.price_bits[62:52];
	assign mant = {bexp != '0, q_job.price_bits[51:0]};

	// The exact product is below 2^80; for a normal input its top bit sits at 79 or 78.
	always_comb begin
		if (prod_s2[79]) begin
			top53  = prod_s2[79:27];
			guard  = prod_s2[26];
			sticky = prod_s2[25:0] != '0;
			exp_c  = $signed({2'b00, job_s2.price_bits[62:52]}) + 13'sd27 - 13'sd1075;
		end else begin
			top53  = prod_s2[78:26];
			guard  = prod_s2[25];
			sticky = prod_s2[24:0] != '0;
			exp_c  = $signed({2'b00, job_s2.price_bits[62:52]}) + 13'sd26 - 13'sd1075;
		end
		rnd_c = {1'b0, top53} + 54'(guard && (sticky || top53[0]));
	end

	assign wide_r = {10'b0, rnd_s3};
	assign neg_e  = 13'(-exp_s3);
	assign shl    = wide_r << exp_s3[3:0];

	always_comb begin
		if (sat_s3) begin
			fix_c = INT64_MAX;
		end else if (zero_s3) begin
			fix_c = '0;
		end else if (!exp_s3[12]) begin
			if (exp_s3 > 13'sd10 || shl[63]) begin
				fix_c = INT64_MAX;
			end else begin
				fix_c = shl;
			end
		end else if (neg_e >= 13'd54) begin
			fix_c = '0;
		end else begin
			fix_c = wide_r >> neg_e[5:0];
		end
	end

	assign out_valid = job_q.has_level || job_q.has_report;
	assign advance   = !out_valid || (out_ready && !(job_q.has_level && job_q.has_report));
	assign pop       = advance && !q_empty;

	always_ff @(posedge clk) begin
		if (advance) begin
			job_s1  <= q_job;
			plo_s1  <= 54'(mant[26:0] * PRICE_SCALE);
			phi_s1  <= 53'(mant[52:27] * PRICE_SCALE);
			job_s2  <= job_s1;
			prod_s2 <= {phi_s1, 27'b0} + 80'(plo_s1);
			job_s3  <= job_s2;
			rnd_s3  <= rnd_c;
			exp_s3  <= exp_c;
			zero_s3 <= !job_s2.present || job_s2.price_bits[62:52] == '0;
			sat_s3  <= job_s2.price_bits[62:52] == 11'h7FF;
			job_s4  <= job_s3;
			fix_s4  <= fix_c;
			fix_q   <= fix_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			job_q  <= '0;
		end else if (advance) begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			job_q  <= vld_s4 ? job_s4 : '0;
		end else if (out_ready) begin
			// Level word taken; the report of the same byte follows.
			job_q.has_level <= 1'b0;
		end
	end

	assign show_lvl = job_q.has_level;

	always_comb begin
		result_kind     = !show_lvl;
		instrument_id   = show_lvl ? job_q.instrument_id : '0;
		side            = show_lvl && job_q.side;
		sequence_number = show_lvl ? job_q.sequence_number : '0;
		level_index     = show_lvl ? job_q.level_index : '0;
		last_level      = show_lvl && job_q.last_level;
		level_present   = show_lvl && job_q.present;
		price_fixed     = level_present ? fix_q : '0;
		quantity        = level_present ? job_q.quantity : '0;
		order_count     = level_present ? job_q.order_count : '0;
		bytes_parsed    = show_lvl ? '0 : job_q.bytes_parsed;
	end

endmodule

// File: rtl/core/depth_feed_packet_decoder_top.sv
// Depth feed packet decoder. Takes one feed byte per cycle while in_ready is high (a
// word per byte, with buffer_end on the last byte of a buffer) and splits it into fixed
// 412-byte depth packets: a 12-byte little-endian header followed by 20 levels of price
// (IEEE double), quantity and order count. Packets whose length field is wrong or whose
// response code matches neither the bid nor the ask response code are skipped but still
// counted. Each level of a good packet yields one result word, with the price scaled by
// 1e8, rounded to double precision, truncated toward zero and saturated to the signed
// 64-bit range. A buffer_end byte yields a report word with the bytes consumed in whole
// packets, after the level word if both fall on the same byte. The block sustains one
// byte per cycle while the output is ready; a result passes through the queue, the price
// pipeline and the output register. The rate is set by the front parser, which takes a
// byte every cycle while the four-entry queue has room; the only slower case is a byte
// that yields two words, which stalls the back end until its level word is taken.
// Write the response code registers only while the block is idle.
module depth_feed_packet_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        buffer_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [31:0] instrument_id,
	output logic        side,
	output logic [31:0] sequence_number,
	output logic [5:0]  level_index,
	output logic [63:0] price_fixed,
	output logic [63:0] quantity,
	output logic [31:0] order_count,
	output logic        level_present,
	output logic        last_level,
	output logic [31:0] bytes_parsed
);
	import dfpd_pkg::*;

	logic [7:0] bid_resp_q;
	logic [7:0] ask_resp_q;
	logic       accept;
	logic       push;
	logic       pop;
	logic       q_full;
	logic       q_empty;
	job_t       wr_job;
	job_t       rd_job;

	// Code registers; the bid and ask response codes reset to 41 and 51.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_resp_q <= 8'd41;
			ask_resp_q <= 8'd51;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BID) begin
				bid_resp_q <= cfg_data;
			end else begin
				ask_resp_q <= cfg_data;
			end
		end
	end

	// A byte is taken whenever the queue can hold whatever it may produce.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	dfpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.buffer_end (buffer_end),
		.bid_resp   (bid_resp_q),
		.ask_resp   (ask_resp_q),
		.push       (push),
		.job        (wr_job)
	);

	dfpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.rd_job (rd_job)
	);

	// The back end converts the price in a four-stage pipeline and holds the
	// finished word in an output register.
	dfpd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_job           (rd_job),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.result_kind     (result_kind),
		.instrument_id   (instrument_id),
		.side            (side),
		.sequence_number (sequence_number),
		.level_index     (level_index),
		.price_fixed     (price_fixed),
		.quantity        (quantity),
		.order_count     (order_count),
		.level_present   (level_present),
		.last_level      (last_level),
		.bytes_parsed    (bytes_parsed)
	);

endmodule
